// ----- hdl/vtp_pkg.sv -----
// Shared types and constants for the vertex transform with perspective divide.
package vtp_pkg;

  localparam int COORD_W = 32;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int FRAC_W  = 16;
  localparam int DOT_W   = 50;
  localparam int MAG_W   = DOT_W;
  localparam int QBITS   = 33;
  localparam int NUM_REGS = 8;
  localparam int IDX_W   = 4;
  localparam int REG_W   = 64;

  localparam logic [COORD_W-1:0] ONE_Q16  = 32'h0001_0000;
  localparam logic [COORD_W-1:0] POS_MAX  = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] NEG_MAX  = 32'h8000_0000;

  localparam logic [REG_W-1:0] RST_ROW0_A = 64'h0000_0000_0001_0000;
  localparam logic [REG_W-1:0] RST_ROW1_A = 64'h0001_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_ROW2_B = 64'h0000_0000_0001_0000;
  localparam logic [REG_W-1:0] RST_ROW3_B = 64'h0001_0000_0000_0000;

  localparam logic [IDX_W-1:0] REG_ROW0_A = 4'd0;
  localparam logic [IDX_W-1:0] REG_ROW0_B = 4'd1;
  localparam logic [IDX_W-1:0] REG_ROW1_A = 4'd2;
  localparam logic [IDX_W-1:0] REG_ROW1_B = 4'd3;
  localparam logic [IDX_W-1:0] REG_ROW2_A = 4'd4;
  localparam logic [IDX_W-1:0] REG_ROW2_B = 4'd5;
  localparam logic [IDX_W-1:0] REG_ROW3_A = 4'd6;
  localparam logic [IDX_W-1:0] REG_ROW3_B = 4'd7;

  typedef logic [3:0][3:0][COORD_W-1:0] vtp_mat_t;

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [QBITS-1:0] low;
    logic [QBITS-1:0] quo;
    logic             nneg;
    logic             nz;
    logic             qneg;
    logic             ovf;
  } vtp_lane_t;

  typedef struct packed {
    vtp_lane_t [2:0]  lane;
    logic [MAG_W-1:0] den;
    logic             wzero;
    logic             mode1;
  } vtp_div_t;

endpackage

// ----- hdl/vtp_cfg.sv -----
// Matrix configuration registers, reset to identity.
module vtp_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [vtp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [vtp_pkg::REG_W-1:0]   cfg_data,
  output vtp_pkg::vtp_mat_t           mat
);
  import vtp_pkg::*;

  logic [NUM_REGS-1:0][REG_W-1:0] regs;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_ROW0_A[2:0]] <= RST_ROW0_A;
      regs[REG_ROW0_B[2:0]] <= '0;
      regs[REG_ROW1_A[2:0]] <= RST_ROW1_A;
      regs[REG_ROW1_B[2:0]] <= '0;
      regs[REG_ROW2_A[2:0]] <= '0;
      regs[REG_ROW2_B[2:0]] <= RST_ROW2_B;
      regs[REG_ROW3_A[2:0]] <= '0;
      regs[REG_ROW3_B[2:0]] <= RST_ROW3_B;
    end else if (cfg_valid && cfg_ready && (cfg_index <= REG_ROW3_B)) begin
      regs[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mat[r][0] = regs[2*r][COORD_W-1:0];
      mat[r][1] = regs[2*r][REG_W-1:COORD_W];
      mat[r][2] = regs[2*r+1][COORD_W-1:0];
      mat[r][3] = regs[2*r+1][REG_W-1:COORD_W];
    end
  end

endmodule

// ----- hdl/vtp_dot.sv -----
// Multiply, row sum and divider set-up: three pipeline stages.
module vtp_dot (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         ready,
  input  logic                         mode,
  input  logic [vtp_pkg::COORD_W-1:0]  in_x,
  input  logic [vtp_pkg::COORD_W-1:0]  in_y,
  input  logic [vtp_pkg::COORD_W-1:0]  in_z,
  input  logic [vtp_pkg::COORD_W-1:0]  in_w,
  input  vtp_pkg::vtp_mat_t            mat,
  input  logic                         en_down,
  output logic                         out_valid,
  output vtp_pkg::vtp_div_t            out_data
);
  import vtp_pkg::*;

  logic v1, v2, en1, en2, en3;
  logic m1, m2;
  logic signed [PROD_W-1:0] prod [4][4];
  logic signed [DOT_W-1:0]  dot  [4];
  logic [COORD_W-1:0] vec [4];
  vtp_div_t prep;
  logic signed [SUM_W-1:0] sums [4];
  logic [MAG_W-1:0] mag;

  assign en3   = !out_valid || en_down;
  assign en2   = !v2 || en3;
  assign en1   = !v1 || en2;
  assign ready = en1;

  assign vec[0] = in_x;
  assign vec[1] = in_y;
  assign vec[2] = in_z;
  assign vec[3] = mode ? ONE_Q16 : in_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      m1 <= mode;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          prod[r][c] <= $signed(mat[r][c]) * $signed(vec[c]);
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++)
      sums[r] = SUM_W'(prod[r][0]) + SUM_W'(prod[r][1])
              + SUM_W'(prod[r][2]) + SUM_W'(prod[r][3]);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      m2 <= m1;
      for (int r = 0; r < 4; r++)
        dot[r] <= DOT_W'(sums[r] >>> FRAC_W);
    end
  end

  always_comb begin
    mag = '0;
    prep.mode1 = m2;
    prep.wzero = (dot[3] == '0);
    prep.den   = dot[3][DOT_W-1] ? MAG_W'(-dot[3]) : MAG_W'(dot[3]);
    for (int r = 0; r < 3; r++) begin
      mag = dot[r][DOT_W-1] ? MAG_W'(-dot[r]) : MAG_W'(dot[r]);
      prep.lane[r].nneg = dot[r][DOT_W-1];
      prep.lane[r].nz   = (dot[r] != '0);
      prep.lane[r].qneg = dot[r][DOT_W-1] ^ dot[3][DOT_W-1];
      prep.lane[r].rem  = mag >> 17;
      prep.lane[r].ovf  = (mag >> 17) >= prep.den;
      prep.lane[r].low  = {mag[16:0], 16'b0};
      prep.lane[r].quo  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) out_data <= prep;
  end

endmodule

// ----- hdl/vtp_div_step.sv -----
// One restoring-division stage: one quotient bit for each of the three lanes.
module vtp_div_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  vtp_pkg::vtp_div_t in_data,
  input  logic              en_down,
  output logic              ready,
  output logic              out_valid,
  output vtp_pkg::vtp_div_t out_data
);
  import vtp_pkg::*;

  vtp_div_t nxt;
  logic [MAG_W:0] trial [3];
  logic [MAG_W:0] diff  [3];
  logic           ge    [3];

  assign ready = !out_valid || en_down;

  always_comb begin
    nxt = in_data;
    for (int r = 0; r < 3; r++) begin
      trial[r] = {in_data.lane[r].rem, in_data.lane[r].low[QBITS-1]};
      diff[r]  = trial[r] - {1'b0, in_data.den};
      ge[r]    = trial[r] >= {1'b0, in_data.den};
      nxt.lane[r].rem = ge[r] ? diff[r][MAG_W-1:0] : trial[r][MAG_W-1:0];
      nxt.lane[r].quo = {in_data.lane[r].quo[QBITS-2:0], ge[r]};
      nxt.lane[r].low = {in_data.lane[r].low[QBITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ready) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ready) out_data <= nxt;
  end

endmodule

// ----- hdl/vertex_transform_perspective.sv -----
// Top level: 4x4 matrix times vertex with pipelined perspective divide.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, mode, in_x..in_w      | request in
//  out     | out_valid, out_stall, out_x..out_w, flags | request out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | write in
//
// One request per cycle while in_stall is low; stages are multiply, row sum, set-up,
// 33 divider bit stages, saturation/output register.
// Each stage advances when its successor is empty or advancing, so bubbles
// collapse under out_stall. Synchronous reset empties the pipeline and loads
// the identity matrix. cfg_ready is always high.
module vertex_transform_perspective (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         mode,
  input  logic [vtp_pkg::COORD_W-1:0]  in_x,
  input  logic [vtp_pkg::COORD_W-1:0]  in_y,
  input  logic [vtp_pkg::COORD_W-1:0]  in_z,
  input  logic [vtp_pkg::COORD_W-1:0]  in_w,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [vtp_pkg::COORD_W-1:0]  out_x,
  output logic [vtp_pkg::COORD_W-1:0]  out_y,
  output logic [vtp_pkg::COORD_W-1:0]  out_z,
  output logic [vtp_pkg::COORD_W-1:0]  out_w,
  output logic                         div_zero,
  output logic                         saturated,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [vtp_pkg::IDX_W-1:0]    cfg_index,
  input  logic [vtp_pkg::REG_W-1:0]    cfg_data
);
  import vtp_pkg::*;

  vtp_mat_t mat;
  logic     dot_ready;
  logic     en_out;
  logic     sv [QBITS+1];
  vtp_div_t sd [QBITS+1];
  logic     rdy [QBITS+1];

  logic [COORD_W-1:0] res [3];
  logic [2:0]         sat;
  vtp_div_t           fin;

  vtp_cfg u_cfg (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mat(mat)
  );

  assign in_stall = !dot_ready;

  vtp_dot u_dot (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .ready(dot_ready),
    .mode(mode), .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_w(in_w),
    .mat(mat),
    .en_down(rdy[0]),
    .out_valid(sv[0]), .out_data(sd[0])
  );

  assign en_out     = !out_valid || !out_stall;
  assign rdy[QBITS] = en_out;

  for (genvar i = 0; i < QBITS; i++) begin : g_div
    vtp_div_step u_step (
      .clk(clk), .rst(rst),
      .in_valid(sv[i]), .in_data(sd[i]),
      .en_down(rdy[i+1]), .ready(rdy[i]),
      .out_valid(sv[i+1]), .out_data(sd[i+1])
    );
  end

  assign fin = sd[QBITS];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sat[r] = 1'b0;
      if (fin.wzero) begin
        res[r] = !fin.lane[r].nz ? '0 : (fin.lane[r].nneg ? NEG_MAX : POS_MAX);
      end else if (fin.lane[r].qneg) begin
        if (fin.lane[r].ovf || fin.lane[r].quo > {1'b0, NEG_MAX}) begin
          res[r] = NEG_MAX;
          sat[r] = 1'b1;
        end else begin
          res[r] = -fin.lane[r].quo[COORD_W-1:0];
        end
      end else begin
        if (fin.lane[r].ovf || fin.lane[r].quo > {1'b0, POS_MAX}) begin
          res[r] = POS_MAX;
          sat[r] = 1'b1;
        end else begin
          res[r] = fin.lane[r].quo[COORD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en_out) out_valid <= sv[QBITS];
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_x     <= res[0];
      out_y     <= res[1];
      out_z     <= res[2];
      out_w     <= (fin.wzero && !fin.mode1) ? '0 : ONE_Q16;
      div_zero  <= fin.wzero;
      saturated <= |sat;
    end
  end

endmodule

// ----- dv/vtp_checker.sv -----
// Checker for the vertex transform: watches all channels, predicts each vertex and compares.
module vtp_checker
  import vtp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               mode,
  input  logic [COORD_W-1:0] in_x,
  input  logic [COORD_W-1:0] in_y,
  input  logic [COORD_W-1:0] in_z,
  input  logic [COORD_W-1:0] in_w,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [COORD_W-1:0] out_x,
  input  logic [COORD_W-1:0] out_y,
  input  logic [COORD_W-1:0] out_z,
  input  logic [COORD_W-1:0] out_w,
  input  logic               div_zero,
  input  logic               saturated,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]   cfg_data,
  output int                 fails,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] w;
    logic               dz;
    logic               sat;
  } vertex_res_t;

  logic [REG_W-1:0] matrix_regs [NUM_REGS];
  vertex_res_t      vertex_q [$];

  assign pending = vertex_q.size();

  function automatic logic signed [DOT_W-1:0] row_dot(int r, logic [3:0][COORD_W-1:0] v);
    logic signed [SUM_W-1:0]   acc;
    logic signed [PROD_W-1:0]  p;
    logic signed [COORD_W-1:0] m;
    acc = '0;
    for (int c = 0; c < 4; c++) begin
      m = (c & 1) ? matrix_regs[r*2 + c/2][63:32] : matrix_regs[r*2 + c/2][31:0];
      p = m * $signed(v[c]);
      acc += SUM_W'(p);
    end
    return DOT_W'(acc >>> FRAC_W);
  endfunction

  function automatic logic [COORD_W-1:0] q16_div(logic signed [DOT_W-1:0] n,
                                                 logic signed [DOT_W-1:0] d,
                                                 output bit clip);
    logic signed [63:0] n64, d64;
    logic [63:0]        un, ud, qi, mag;
    bit                 neg;
    n64 = n;
    d64 = d;
    un = (n64 < 0) ? -n64 : n64;
    ud = (d64 < 0) ? -d64 : d64;
    neg = (n64 < 0) != (d64 < 0);
    qi = un / ud;
    clip = 0;
    if (qi > 64'd32768) mag = 64'h1_0000_0000;
    else mag = (qi << 16) + ((un % ud) << 16) / ud;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        clip = 1;
        return NEG_MAX;
      end
      return COORD_W'(64'd0 - mag);
    end
    if (mag > 64'h7FFF_FFFF) begin
      clip = 1;
      return POS_MAX;
    end
    return COORD_W'(mag);
  endfunction

  function automatic vertex_res_t transform(logic m1, logic [3:0][COORD_W-1:0] v);
    vertex_res_t                 res;
    logic signed [DOT_W-1:0]     num [3];
    logic signed [DOT_W-1:0]     wd;
    logic [2:0][COORD_W-1:0]     q;
    bit                          clip;
    if (m1) v[3] = ONE_Q16;
    for (int r = 0; r < 3; r++) num[r] = row_dot(r, v);
    wd = row_dot(3, v);
    res = '0;
    if (wd == 0) begin
      for (int r = 0; r < 3; r++)
        q[r] = (num[r] > 0) ? POS_MAX : (num[r] < 0) ? NEG_MAX : '0;
      res.w  = m1 ? ONE_Q16 : '0;
      res.dz = 1;
    end else begin
      for (int r = 0; r < 3; r++) begin
        q[r] = q16_div(num[r], wd, clip);
        res.sat |= clip;
      end
      res.w = ONE_Q16;
    end
    res.x = q[0];
    res.y = q[1];
    res.z = q[2];
    return res;
  endfunction

  task automatic check_field(string name, logic [COORD_W-1:0] exp_v, logic [COORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fails++;
    end
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    vertex_res_t exp_r;
    if (rst) begin
      matrix_regs[0] <= RST_ROW0_A;
      matrix_regs[1] <= '0;
      matrix_regs[2] <= RST_ROW1_A;
      matrix_regs[3] <= '0;
      matrix_regs[4] <= '0;
      matrix_regs[5] <= RST_ROW2_B;
      matrix_regs[6] <= '0;
      matrix_regs[7] <= RST_ROW3_B;
      vertex_q.delete();
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
        matrix_regs[cfg_index[2:0]] <= cfg_data;
      if (in_valid && !in_stall)
        vertex_q.push_back(transform(mode, {in_w, in_z, in_y, in_x}));
      if (out_valid && !out_stall) begin
        if (vertex_q.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          exp_r = vertex_q.pop_front();
          check_field("out_x", exp_r.x, out_x);
          check_field("out_y", exp_r.y, out_y);
          check_field("out_z", exp_r.z, out_z);
          check_field("out_w", exp_r.w, out_w);
          check_field("div_zero", 32'(exp_r.dz), 32'(div_zero));
          check_field("saturated", 32'(exp_r.sat), 32'(saturated));
        end
      end
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top: clock, reset, vertex and matrix stimulus, and the verdict.
module tb_top;
  import vtp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 40;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               mode;
  logic [COORD_W-1:0] in_x, in_y, in_z, in_w;
  logic               out_valid;
  logic               out_stall;
  logic [COORD_W-1:0] out_x, out_y, out_z, out_w;
  logic               div_zero, saturated;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index;
  logic [REG_W-1:0]   cfg_data;
  int                 fails, pending;

  int stall_pct;
  int hold_reqs, hold_seen;

  vertex_transform_perspective DUT (.*);

  vtp_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stall pattern, plus long hold-offs on request
  initial begin
    int hold_left;
    out_stall = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return COORD_W'($signed($urandom_range(0, 16*65536)) - 8*65536);
      2: return COORD_W'($signed($urandom_range(0, 1024*65536)) - 512*65536);
      3: case ($urandom_range(0, 4))
           0: return POS_MAX;
           1: return NEG_MAX;
           2: return '0;
           3: return 32'h1;
           default: return '1;
         endcase
      default: return COORD_W'($signed($urandom_range(0, 4*65536)) - 2*65536);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_elem(int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 1) ? POS_MAX : NEG_MAX;
      default: return COORD_W'($signed($urandom_range(0, 8*65536)) - 4*65536);
    endcase
  endfunction

  task automatic send_vertex(logic m, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COORD_W-1:0] z, logic [COORD_W-1:0] w);
    in_valid <= 1;
    mode <= m;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    in_w <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_matrix(int kind);
    logic [3:0][3:0][COORD_W-1:0] m;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        m[r][c] = rand_elem(kind == 3 ? 2 : kind);
    if (kind == 3) begin
      // perspective: w taken from z or its negation, row 3 otherwise empty
      m[3] = '0;
      m[3][2] = $urandom_range(0, 1) ? ONE_Q16 : -ONE_Q16;
    end
    if (kind == 4) m[3] = '0;
    cfg_valid <= 1;
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_index <= IDX_W'(i);
      cfg_data <= {m[i/2][(i%2)*2+1], m[i/2][(i%2)*2]};
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_index <= IDX_W'($urandom_range(NUM_REGS, 15));
    cfg_data <= {$urandom, $urandom};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic run_random(int n, bit with_hold);
    int burst;
    burst = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == 5) hold_reqs++;
      send_vertex(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord());
      if (!(with_hold && i < 70) && --burst == 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst = $urandom_range(1, 12);
      end
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    mode = 0;
    in_x = '0;
    in_y = '0;
    in_z = '0;
    in_w = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    stall_pct = 0;
    hold_reqs = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // identity matrix after reset
    send_vertex(0, '0, '0, '0, '0);
    send_vertex(0, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, ONE_Q16);
    send_vertex(0, 32'h0003_0000, 32'hFFFF_0000, '0, 32'h0000_8000);
    send_vertex(0, POS_MAX, NEG_MAX, 32'h1, 32'h1);
    send_vertex(0, NEG_MAX, POS_MAX, '1, -ONE_Q16);
    send_vertex(0, 32'h0005_0000, 32'hFFFB_0000, '0, '0);
    send_vertex(0, POS_MAX, NEG_MAX, '0, '0);
    send_vertex(1, 32'h0001_8000, 32'hFFFE_8000, POS_MAX, '0);
    send_vertex(1, NEG_MAX, POS_MAX, '1, NEG_MAX);
    send_vertex(1, '0, '0, '0, POS_MAX);
    send_vertex(0, '1, '1, '1, '1);
    send_vertex(0, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
    send_vertex(0, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX);
    send_vertex(0, 32'h0000_4000, 32'h0000_0001, 32'h7FFF_0000, 32'h0000_0002);
    send_vertex(1, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001, '0);
    drain();

    // an extreme matrix, then a matrix whose w row is zero
    write_matrix(1);
    for (int i = 0; i < 4; i++)
      send_vertex(1'(i % 2), rand_coord(), rand_coord(), rand_coord(), rand_coord());
    drain();
    write_matrix(4);
    send_vertex(0, 32'h0001_0000, 32'hFFFF_0000, '0, ONE_Q16);
    send_vertex(1, POS_MAX, NEG_MAX, '0, '0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 60);
      write_matrix(ph % 5 == 1 ? 0 : ph % 5 == 2 ? 3 : ph % 5 == 4 ? 4 : 2);
      run_random(65, ph == 2 || ph == 6);
      drain();
    end

    if (fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
